// File: src/imu_complementary_tilt_filter_assert.svh
// assertion macros for the tilt filter checker
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// same-cycle implication
`define ICTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ictf assertion failed");

// next-cycle implication
`define ICTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ictf assertion failed");

`endif

// File: src/ictf_pkg.sv
`timescale 1ns / 1ps

package ictf_pkg;

   // port widths
   localparam int REQ_W      = 64;
   localparam int RSP_W      = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // cordic sizing
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ATAN_IDX_W       = 5;
   localparam int ANGLE_W          = 24;
   localparam int SEED_W           = 21;
   localparam int CORD_FRAC        = 20;
   localparam int CORD_W           = 42;

   // shared multiplier
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SAT_IN_W = 36;

   localparam logic [4:0] YAW_SHIFT    = 5'd9;
   localparam logic [4:0] PITCH_SHIFT  = 5'd8;
   localparam logic [4:0] FUSION_SHIFT = 5'd24;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_Z_ZERO     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_YAW_GAIN        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PITCH_GYRO_GAIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_FUSION_GAIN     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TILT_LIMIT      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_STARTUP_TICKS   = 3'd5;

   // register reset values
   localparam logic signed [16:0] GYRO_Z_ZERO_RST     = -17'sd2;
   localparam logic [23:0]        YAW_GAIN_RST        = 24'd2094;
   localparam logic [23:0]        PITCH_GYRO_GAIN_RST = 24'd2096;
   localparam logic [23:0]        FUSION_GAIN_RST     = 24'd16777;
   localparam logic [22:0]        TILT_LIMIT_RST      = 23'd5832704;
   localparam logic [9:0]         STARTUP_TICKS_RST   = 10'd300;

   // cordic status toward the sequencer
   typedef struct packed {
      logic                      busy;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_out_type;

   // arctan(2^-i) in degrees, q16.16
   function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = 24'sd2949120;
         5'd1:    val = 24'sd1740967;
         5'd2:    val = 24'sd919879;
         5'd3:    val = 24'sd466945;
         5'd4:    val = 24'sd234379;
         5'd5:    val = 24'sd117304;
         5'd6:    val = 24'sd58666;
         5'd7:    val = 24'sd29335;
         5'd8:    val = 24'sd14668;
         5'd9:    val = 24'sd7334;
         5'd10:   val = 24'sd3667;
         5'd11:   val = 24'sd1833;
         5'd12:   val = 24'sd917;
         5'd13:   val = 24'sd458;
         5'd14:   val = 24'sd229;
         5'd15:   val = 24'sd115;
         5'd16:   val = 24'sd57;
         5'd17:   val = 24'sd29;
         5'd18:   val = 24'sd14;
         5'd19:   val = 24'sd7;
         5'd20:   val = 24'sd4;
         5'd21:   val = 24'sd2;
         5'd22:   val = 24'sd1;
         default: val = 24'sd0;
      endcase
      return val;
   endfunction

   // arithmetic right shift, rounding to nearest with ties away from zero
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v,
      input logic [4:0]               sh
   );
      logic signed [PROD_W-1:0] half;
      logic signed [PROD_W-1:0] bias;
      half = PROD_W'(1) << (sh - 5'd1);
      bias = half - PROD_W'(v[PROD_W-1]);
      return (v + bias) >>> sh;
   endfunction

   // clip to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
      logic signed [31:0] res;
      if (v[SAT_IN_W-1] && !(&v[SAT_IN_W-2:31])) begin
         res = 32'sh8000_0000;
      end else if (!v[SAT_IN_W-1] && (|v[SAT_IN_W-2:31])) begin
         res = 32'sh7fff_ffff;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// File: src/ictf_cordic.sv
`timescale 1ns / 1ps

module ictf_cordic #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [15:0]      acc_x,
   input  logic signed [15:0]      acc_z,
   output ictf_pkg::cordic_out_type cordic_out
);

   localparam int EXT_W = ictf_pkg::CORD_W - ictf_pkg::SEED_W - ictf_pkg::CORD_FRAC;

   logic                                  busy_ff, busy_in;
   logic [ictf_pkg::ATAN_IDX_W-1:0]       iter_ff, iter_in;
   logic signed [ictf_pkg::CORD_W-1:0]    x_ff, x_in;
   logic signed [ictf_pkg::CORD_W-1:0]    y_ff, y_in;
   logic signed [ictf_pkg::ANGLE_W-1:0]   z_ff, z_in;

   logic signed [ictf_pkg::SEED_W-1:0]    den, num, den_abs, num_abs;
   logic signed [ictf_pkg::CORD_W-1:0]    dx, dy;
   logic signed [ictf_pkg::ANGLE_W-1:0]   step_angle;

   // seed: 10*acc_z + 1 and 10*acc_x, sign moved so x starts non-negative
   always_comb begin
      den = {{2{acc_z[15]}}, acc_z, 3'b000} + {{4{acc_z[15]}}, acc_z, 1'b0} + 21'sd1;
      num = {{2{acc_x[15]}}, acc_x, 3'b000} + {{4{acc_x[15]}}, acc_x, 1'b0};
      den_abs = den[ictf_pkg::SEED_W-1] ? -den : den;
      num_abs = den[ictf_pkg::SEED_W-1] ? -num : num;
   end

   // one vectoring rotation per cycle
   always_comb begin
      dx         = y_ff >>> iter_ff;
      dy         = x_ff >>> iter_ff;
      step_angle = ictf_pkg::atan_q16(iter_ff);
      busy_in    = busy_ff;
      iter_in    = iter_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in    = {{EXT_W{den_abs[ictf_pkg::SEED_W-1]}}, den_abs,
                    {ictf_pkg::CORD_FRAC{1'b0}}};
         y_in    = {{EXT_W{num_abs[ictf_pkg::SEED_W-1]}}, num_abs,
                    {ictf_pkg::CORD_FRAC{1'b0}}};
         z_in    = '0;
      end else if (busy_ff) begin
         if (!y_ff[ictf_pkg::CORD_W-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ictf_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign cordic_out.busy  = busy_ff;
   assign cordic_out.angle = z_ff;

endmodule

// File: src/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps

// Complementary tilt filter for a 6-axis IMU. Each request word carries raw gyro y/z and
// accel x/z samples; each one produces exactly one response word with the integrated yaw,
// the published pitch (both signed Q16.16 degrees) and a ready flag in tuser that is high
// once the startup ticks have passed. The accel tilt comes from an iterative CORDIC
// vectoring unit running one rotation per cycle, while one shared multiplier handles the
// yaw, gyro pitch and fusion products in turn. The CORDIC iterations set when a response
// is valid; req_tready is low from acceptance until the result moves into the output
// register, so a new word is taken only once the last one is finished. A finished
// response sits in the output register, so the next request is taken while it waits;
// that next item then holds at its last step until the register is free. The user must
// write gains and limits through the csr port while the block is idle; the block itself
// does not enforce this. Writes to unused indexes are dropped.
module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: gyro_y [15:0], gyro_z [31:16], acc_x [47:32], acc_z [63:48]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ictf_pkg::REQ_W-1:0]      req_tdata,
   // response: yaw_angle [31:0], pitch_angle [63:32]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ictf_pkg::RSP_W-1:0]      rsp_tdata,
   // response: pitch_ready [0]
   output logic                            rsp_tuser,
   // configuration writes
   input  logic                            csr_wen,
   input  logic [ictf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ictf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_YAW_MUL = 4'd1;
   localparam logic [3:0] ST_YAW_ACC = 4'd2;
   localparam logic [3:0] ST_PIT_MUL = 4'd3;
   localparam logic [3:0] ST_PIT_ACC = 4'd4;
   localparam logic [3:0] ST_CORDIC  = 4'd5;
   localparam logic [3:0] ST_SMOOTH  = 4'd6;
   localparam logic [3:0] ST_FUS_MUL = 4'd7;
   localparam logic [3:0] ST_FUS_ACC = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   localparam int AW = ictf_pkg::ANGLE_W;
   localparam int SW = ictf_pkg::SAT_IN_W;

   // configuration registers
   logic signed [16:0] zero_ff;
   logic [23:0]        yaw_gain_ff;
   logic [23:0]        pitch_gain_ff;
   logic [23:0]        fusion_gain_ff;
   logic [22:0]        tilt_limit_ff;
   logic [9:0]         startup_ff;

   // filter state
   logic [3:0]                         state_ff, state_in;
   logic signed [31:0]                 yaw_sum_ff, yaw_sum_in;
   logic signed [AW-1:0]               smooth_ff, smooth_in;
   logic signed [31:0]                 fused_ff, fused_in;
   logic signed [31:0]                 hold_ff, hold_in;
   logic [9:0]                         warm_ff, warm_in;
   logic                               ready_ff, ready_in;

   // working registers
   logic signed [15:0]                 gyro_y_ff, gyro_z_ff;
   logic signed [31:0]                 f1_ff, f1_in;
   logic signed [AW-1:0]               s_ff, s_in;
   logic signed [ictf_pkg::PROD_W-1:0] prod_ff;

   // response register
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [ictf_pkg::RSP_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic                               rsp_tuser_ff, rsp_tuser_in;

   logic                                req_fire;
   ictf_pkg::cordic_out_type            cordic_out;
   logic signed [18:0]                  yaw_rate;
   logic signed [ictf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ictf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ictf_pkg::PROD_W-1:0]  rnd;
   logic [4:0]                          rnd_sh;
   logic signed [SW-1:0]                wide_sum;
   logic signed [31:0]                  sat_val;
   logic signed [AW-1:0]                prev_angle;
   logic signed [AW:0]                  avg_sum;
   logic signed [AW-1:0]                avg;
   logic signed [AW:0]                  lim_pos;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // accel tilt unit, launched on acceptance and run alongside the products
   ictf_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .acc_x      (req_tdata[47:32]),
      .acc_z      (req_tdata[63:48]),
      .cordic_out (cordic_out)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff        <= ictf_pkg::GYRO_Z_ZERO_RST;
         yaw_gain_ff    <= ictf_pkg::YAW_GAIN_RST;
         pitch_gain_ff  <= ictf_pkg::PITCH_GYRO_GAIN_RST;
         fusion_gain_ff <= ictf_pkg::FUSION_GAIN_RST;
         tilt_limit_ff  <= ictf_pkg::TILT_LIMIT_RST;
         startup_ff     <= ictf_pkg::STARTUP_TICKS_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            ictf_pkg::REG_GYRO_Z_ZERO:     zero_ff        <= csr_wdata[16:0];
            ictf_pkg::REG_YAW_GAIN:        yaw_gain_ff    <= csr_wdata;
            ictf_pkg::REG_PITCH_GYRO_GAIN: pitch_gain_ff  <= csr_wdata;
            ictf_pkg::REG_FUSION_GAIN:     fusion_gain_ff <= csr_wdata;
            ictf_pkg::REG_TILT_LIMIT:      tilt_limit_ff  <= csr_wdata[22:0];
            ictf_pkg::REG_STARTUP_TICKS:   startup_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      yaw_rate = {{2{gyro_z_ff[15]}}, gyro_z_ff, 1'b0} - {{2{zero_ff[16]}}, zero_ff};
      case (state_ff)
         ST_YAW_MUL: begin
            mul_a = {{(ictf_pkg::MUL_A_W - 19){yaw_rate[18]}}, yaw_rate};
            mul_b = {1'b0, yaw_gain_ff};
         end
         ST_PIT_MUL: begin
            mul_a = {{(ictf_pkg::MUL_A_W - 16){gyro_y_ff[15]}}, gyro_y_ff};
            mul_b = {1'b0, pitch_gain_ff};
         end
         ST_FUS_MUL: begin
            mul_a = {{(ictf_pkg::MUL_A_W - AW){s_ff[AW-1]}}, s_ff}
                    - {f1_ff[31], f1_ff};
            mul_b = {1'b0, fusion_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // rounding shift and saturating add or subtract on the registered product
   always_comb begin
      case (state_ff)
         ST_YAW_ACC: rnd_sh = ictf_pkg::YAW_SHIFT;
         ST_PIT_ACC: rnd_sh = ictf_pkg::PITCH_SHIFT;
         default:    rnd_sh = ictf_pkg::FUSION_SHIFT;
      endcase
      rnd = ictf_pkg::round_shift(prod_ff, rnd_sh);
      case (state_ff)
         ST_YAW_ACC: wide_sum = SW'(yaw_sum_ff) + SW'(rnd);
         ST_PIT_ACC: wide_sum = SW'(fused_ff) - SW'(rnd);
         default:    wide_sum = SW'(f1_ff) + SW'(rnd);
      endcase
      sat_val = ictf_pkg::sat32(wide_sum);
   end

   // accel angle averaging and clamp
   always_comb begin
      prev_angle = (warm_ff == '0) ? cordic_out.angle : smooth_ff;
      avg_sum    = (AW + 1)'(cordic_out.angle) + (AW + 1)'(prev_angle);
      avg        = avg_sum[AW:1];
      lim_pos    = {{(AW + 1 - 23){1'b0}}, tilt_limit_ff};
      if ((AW + 1)'(avg) > lim_pos) begin
         s_in = lim_pos[AW-1:0];
      end else if ((AW + 1)'(avg) < -lim_pos) begin
         s_in = -lim_pos[AW-1:0];
      end else begin
         s_in = avg;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      yaw_sum_in    = yaw_sum_ff;
      smooth_in     = smooth_ff;
      fused_in      = fused_ff;
      hold_in       = hold_ff;
      warm_in       = warm_ff;
      ready_in      = ready_ff;
      f1_in         = f1_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_YAW_MUL;
            end
         end
         ST_YAW_MUL: state_in = ST_YAW_ACC;
         ST_YAW_ACC: begin
            yaw_sum_in = sat_val;
            state_in   = ST_PIT_MUL;
         end
         ST_PIT_MUL: state_in = ST_PIT_ACC;
         ST_PIT_ACC: begin
            f1_in    = sat_val;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!cordic_out.busy) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            smooth_in = s_in;
            state_in  = ST_FUS_MUL;
         end
         ST_FUS_MUL: state_in = ST_FUS_ACC;
         ST_FUS_ACC: begin
            // startup forces the fused angle onto the accel angle
            if (warm_ff < startup_ff) begin
               fused_in = {{(32 - AW){s_ff[AW-1]}}, s_ff};
               warm_in  = warm_ff + 1'b1;
               ready_in = 1'b0;
            end else begin
               fused_in = sat_val;
               hold_in  = sat_val;
               ready_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {hold_ff, yaw_sum_ff};
               rsp_tuser_in  = ready_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         yaw_sum_ff    <= '0;
         smooth_ff     <= '0;
         fused_ff      <= '0;
         hold_ff       <= '0;
         warm_ff       <= '0;
         ready_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         yaw_sum_ff    <= yaw_sum_in;
         smooth_ff     <= smooth_in;
         fused_ff      <= fused_in;
         hold_ff       <= hold_in;
         warm_ff       <= warm_in;
         ready_ff      <= ready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         gyro_y_ff <= req_tdata[15:0];
         gyro_z_ff <= req_tdata[31:16];
      end
      if (state_ff == ST_SMOOTH) begin
         s_ff <= s_in;
      end
      f1_ff        <= f1_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// File: src/ictf_checker.sv
`timescale 1ns / 1ps

`include "imu_complementary_tilt_filter_assert.svh"

module ictf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ictf_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tuser
);

   // a stalled response word holds its payload
   `ICTF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

   // the unit is busy right after taking a word
   `ICTF_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new response only comes out of a busy cycle
   `ICTF_ASSERT_IMP(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (.*);

// File: bench/imu_complementary_tilt_filter_tb.sv
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_tb;

   localparam int HALF_PERIOD      = 5;
   localparam int NUM_PHASES       = 8;
   localparam int FIRST_RAND_WORDS = 290;
   localparam int PHASE_WORDS      = 195;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;

   // indexes that decode to no register
   localparam logic [ictf_pkg::CSR_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [ictf_pkg::CSR_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

   // 90 degrees in q16.16
   localparam logic [22:0] TILT_NINETY = 23'd5898240;

   // arctan(2^-i) in degrees, q16.16
   localparam longint ATAN_DEG [ictf_pkg::ATAN_ENTRIES] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [31:0] yaw;
      logic signed [31:0] pitch;
      logic               ready;
   } attitude_type;

   typedef struct packed {
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic signed [15:0] ax;
      logic signed [15:0] az;
      logic signed [31:0] pitch;
      logic               ready;
   } imu_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ictf_pkg::REQ_W-1:0]      req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ictf_pkg::RSP_W-1:0]      rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_wen;
   logic [ictf_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [ictf_pkg::CSR_DATA_W-1:0] csr_wdata;

   // register copies
   logic signed [16:0] cfg_gz_zero;
   logic [23:0]        cfg_yaw_gain;
   logic [23:0]        cfg_pitch_gain;
   logic [23:0]        cfg_fusion_gain;
   logic [22:0]        cfg_tilt_limit;
   logic [9:0]         cfg_startup;

   // filter state copies
   logic signed [31:0] m_yaw_sum;
   logic signed [31:0] m_accel_smooth;
   logic signed [31:0] m_fused;
   logic signed [31:0] m_pitch_hold;
   logic [9:0]         m_warmup;

   attitude_type pending_attitude [$];

   int errors        = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int published     = 0;
   int tx_gap_pct    = 0;
   int rx_stall_pct  = 0;

   // directed words: field extremes, zero and negative acc_z, bit patterns;
   // all fall inside the default startup window, so pitch stays zero and not ready
   imu_row_type dir_rows [0:21] = '{
      '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sd100,  -16'sd1,   32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, -16'sd100, -16'sd1,   32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff, 32'sd0, 1'b0},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sd0, 1'b0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, 16'sd1,    16'sh0000, 32'sd0, 1'b0},
      '{16'sh0000, 16'sh0000, -16'sd1,   16'sh0000, 32'sd0, 1'b0},
      '{16'sd1,    -16'sd1,   16'sd16384, 16'sd16384, 32'sd0, 1'b0},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 32'sd0, 1'b0},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 32'sd0, 1'b0}
   };

   imu_complementary_tilt_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // shift right, nearest with ties away from zero
   function automatic longint round_away(input longint v, input int sh);
      longint half;
      half = longint'(1) <<< (sh - 1);
      if (v < 0) begin
         return -(((-v) + half) >>> sh);
      end
      return (v + half) >>> sh;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > longint'(32'sh7fff_ffff)) begin
         return longint'(32'sh7fff_ffff);
      end
      if (v < longint'(32'sh8000_0000)) begin
         return longint'(32'sh8000_0000);
      end
      return v;
   endfunction

   // accel tilt in degrees q16.16 by cordic vectoring on 10*ax / (10*az + 1)
   function automatic longint tilt_deg(input logic signed [15:0] ax,
                                       input logic signed [15:0] az);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = 10 * longint'(az) + 1;
      y = 10 * longint'(ax);
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
      end
      x = x * 1048576;
      y = y * 1048576;
      for (int i = 0; i < ictf_pkg::CORDIC_STEPS_DEF && i < ictf_pkg::ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_DEG[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_DEG[i];
         end
      end
      return z;
   endfunction

   // one sample tick of the filter: updates the state copies, returns the attitude word
   function automatic attitude_type filter_tick(input logic signed [15:0] gy,
                                                input logic signed [15:0] gz,
                                                input logic signed [15:0] ax,
                                                input logic signed [15:0] az);
      longint       inc;
      longint       acc;
      longint       prev;
      longint       sm;
      longint       lim;
      longint       f;
      attitude_type r;
      // yaw integration
      inc = round_away((2 * longint'(gz) - longint'(cfg_gz_zero)) * longint'(cfg_yaw_gain), 9);
      m_yaw_sum = 32'(clip32(longint'(m_yaw_sum) + inc));
      // accel angle, averaged with the previous one and clamped
      acc  = tilt_deg(ax, az);
      prev = (m_warmup == 10'd0) ? acc : longint'(m_accel_smooth);
      sm   = (acc + prev) >>> 1;
      lim  = longint'(cfg_tilt_limit);
      if (sm > lim) begin
         sm = lim;
      end
      if (sm < -lim) begin
         sm = -lim;
      end
      m_accel_smooth = 32'(sm);
      // gyro step, then pull toward the accel angle
      f = clip32(longint'(m_fused) - round_away(longint'(gy) * longint'(cfg_pitch_gain), 8));
      f = clip32(f + round_away((sm - f) * longint'(cfg_fusion_gain), 24));
      if (m_warmup < cfg_startup) begin
         f        = sm;
         m_warmup = m_warmup + 10'd1;
         r.ready  = 1'b0;
      end else begin
         m_pitch_hold = 32'(f);
         r.ready      = 1'b1;
      end
      m_fused = 32'(f);
      r.yaw   = m_yaw_sum;
      r.pitch = m_pitch_hold;
      return r;
   endfunction

   function automatic void apply_reg(input logic [ictf_pkg::CSR_ADDR_W-1:0] idx,
                                     input logic [ictf_pkg::CSR_DATA_W-1:0] v);
      case (idx)
         ictf_pkg::REG_GYRO_Z_ZERO:     cfg_gz_zero     = v[16:0];
         ictf_pkg::REG_YAW_GAIN:        cfg_yaw_gain    = v[23:0];
         ictf_pkg::REG_PITCH_GYRO_GAIN: cfg_pitch_gain  = v[23:0];
         ictf_pkg::REG_FUSION_GAIN:     cfg_fusion_gain = v[23:0];
         ictf_pkg::REG_TILT_LIMIT:      cfg_tilt_limit  = v[22:0];
         ictf_pkg::REG_STARTUP_TICKS:   cfg_startup     = v[9:0];
         default: ;
      endcase
   endfunction

   // random bits above the register width, which the block must drop
   function automatic logic [ictf_pkg::CSR_DATA_W-1:0] with_junk(
      input logic [ictf_pkg::CSR_DATA_W-1:0] v,
      input int                              w
   );
      logic [ictf_pkg::CSR_DATA_W-1:0] m;
      m = (24'h1 << w) - 1;
      return (v & m) | (ictf_pkg::CSR_DATA_W'($urandom) & ~m);
   endfunction

   function automatic logic [23:0] gain_draw();
      case ($urandom_range(0, 3))
         0:       return 24'h00_0000;
         1:       return 24'hff_ffff;
         2:       return 24'($urandom_range(0, 65535));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'($urandom_range(0, 64)) - 16'sd32;
         3:       return 16'($urandom_range(0, 2)) - 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // drive one csr write at a falling edge; caller lowers csr_wen after a batch
   task automatic write_reg(input logic [ictf_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [ictf_pkg::CSR_DATA_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(negedge clock);
      apply_reg(idx, v);
   endtask

   task automatic program_phase(input int ph);
      logic signed [16:0] zz;
      logic [23:0]        yg;
      logic [23:0]        pg;
      logic [23:0]        fg;
      logic [22:0]        tl;
      logic [9:0]         st;
      case (ph)
         // low extremes, startup lowered below the running count
         1: begin
            zz = 17'h10000; yg = '1; pg = '1; fg = '0; tl = '0; st = '0;
         end
         // high extremes, tilt limit above 90 degrees, back into forced startup
         2: begin
            zz = 17'h0ffff; yg = '1; pg = '0; fg = '1; tl = '1; st = '1;
         end
         3: begin
            zz = '0; yg = '0; pg = ictf_pkg::PITCH_GYRO_GAIN_RST; fg = 24'($urandom);
            tl = TILT_NINETY; st = '0;
         end
         NUM_PHASES: begin
            zz = ictf_pkg::GYRO_Z_ZERO_RST;
            yg = ictf_pkg::YAW_GAIN_RST;
            pg = ictf_pkg::PITCH_GYRO_GAIN_RST;
            fg = ictf_pkg::FUSION_GAIN_RST;
            tl = ictf_pkg::TILT_LIMIT_RST;
            st = ictf_pkg::STARTUP_TICKS_RST;
         end
         default: begin
            zz = 17'($urandom);
            yg = gain_draw();
            pg = gain_draw();
            fg = gain_draw();
            tl = ($urandom_range(0, 2) == 0) ? TILT_NINETY : 23'($urandom);
            st = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
         end
      endcase
      write_reg(ictf_pkg::REG_GYRO_Z_ZERO, with_junk(ictf_pkg::CSR_DATA_W'(zz), 17));
      write_reg(ictf_pkg::REG_YAW_GAIN, with_junk(yg, 24));
      write_reg(ictf_pkg::REG_PITCH_GYRO_GAIN, with_junk(pg, 24));
      write_reg(ictf_pkg::REG_FUSION_GAIN, with_junk(fg, 24));
      write_reg(ictf_pkg::REG_TILT_LIMIT, with_junk(ictf_pkg::CSR_DATA_W'(tl), 23));
      write_reg(ictf_pkg::REG_STARTUP_TICKS, with_junk(ictf_pkg::CSR_DATA_W'(st), 10));
      // writes to undecoded indexes must leave every register alone
      if (ph % 2 == 1) begin
         write_reg(REG_UNUSED_LO, ictf_pkg::CSR_DATA_W'($urandom));
         write_reg(REG_UNUSED_HI, ictf_pkg::CSR_DATA_W'($urandom));
      end
      csr_wen <= 1'b0;
   endtask

   // offer one sample word, entered at a falling edge, leaves at a falling edge
   task automatic offer(input logic signed [15:0] gy, input logic signed [15:0] gz,
                        input logic signed [15:0] ax, input logic signed [15:0] az,
                        input bit pinned, input logic signed [31:0] pin_pitch,
                        input logic pin_ready);
      attitude_type a;
      req_tdata  <= {az, ax, gz, gy};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      a = filter_tick(gy, gz, ax, az);
      if (pinned) begin
         a.pitch = pin_pitch;
         a.ready = pin_ready;
      end
      pending_attitude.push_back(a);
      words_sent++;
      @(negedge clock);
      if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic offer_random();
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic signed [15:0] ax;
      logic signed [15:0] az;
      gy = draw_sample();
      gz = draw_sample();
      if ($urandom_range(0, 2) == 0) begin
         // near level: gravity on z, modest tilt on x
         az = 16'sd16384 + 16'($urandom_range(0, 4000)) - 16'sd2000;
         if ($urandom_range(0, 1) == 1) begin
            az = -az;
         end
         ax = 16'($urandom_range(0, 16000)) - 16'sd8000;
      end else begin
         ax = draw_sample();
         az = draw_sample();
      end
      offer(gy, gz, ax, az, 1'b0, 32'sd0, 1'b0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_attitude.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // response side: random stalls plus one long hold-off to back up the input
   initial begin : rx_side
      int stall_left;
      int hold_left;
      bit hold_done;
      bit rdy;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && words_checked >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   // compare each accepted response word with the oldest pending attitude
   always @(posedge clock) begin
      attitude_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_attitude.size() == 0) begin
            $error("response word with nothing pending: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            w = pending_attitude.pop_front();
            if ($signed(rsp_tdata[31:0]) !== w.yaw) begin
               $error("yaw_angle: expected %0d, got %0d", w.yaw, $signed(rsp_tdata[31:0]));
               errors++;
            end
            if ($signed(rsp_tdata[63:32]) !== w.pitch) begin
               $error("pitch_angle: expected %0d, got %0d", w.pitch,
                      $signed(rsp_tdata[63:32]));
               errors++;
            end
            if (rsp_tuser !== w.ready) begin
               $error("pitch_ready: expected %0b, got %0b", w.ready, rsp_tuser);
               errors++;
            end
            if (w.ready) begin
               published++;
            end
            words_checked++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("imu_complementary_tilt_filter_tb: done, errors");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      // register and state copies at their reset values
      cfg_gz_zero     = ictf_pkg::GYRO_Z_ZERO_RST;
      cfg_yaw_gain    = ictf_pkg::YAW_GAIN_RST;
      cfg_pitch_gain  = ictf_pkg::PITCH_GYRO_GAIN_RST;
      cfg_fusion_gain = ictf_pkg::FUSION_GAIN_RST;
      cfg_tilt_limit  = ictf_pkg::TILT_LIMIT_RST;
      cfg_startup     = ictf_pkg::STARTUP_TICKS_RST;
      m_yaw_sum       = '0;
      m_accel_smooth  = '0;
      m_fused         = '0;
      m_pitch_hold    = '0;
      m_warmup        = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under reset settings
      tx_gap_pct   = 20;
      rx_stall_pct = 12;
      foreach (dir_rows[i]) begin
         offer(dir_rows[i].gy, dir_rows[i].gz, dir_rows[i].ax, dir_rows[i].az,
               1'b1, dir_rows[i].pitch, dir_rows[i].ready);
      end

      // random words under reset settings, runs past the startup window
      repeat (FIRST_RAND_WORDS) offer_random();
      drain();

      // register settings in turn; the sender waits for all results between them
      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         program_phase(ph);
         case (ph)
            3:          begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            5:          begin tx_gap_pct = 0;  rx_stall_pct = 25; end
            NUM_PHASES: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            default:    begin tx_gap_pct = 25; rx_stall_pct = 15; end
         endcase
         repeat (PHASE_WORDS) offer_random();
         drain();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d sample words across %0d register settings, %0d results compared",
               words_sent, NUM_PHASES + 1, words_checked);
      $display("%0d results carried a published pitch; one long response hold-off applied",
               published);
      if (errors == 0) begin
         $display("imu_complementary_tilt_filter_tb: done, clean");
      end else begin
         $display("imu_complementary_tilt_filter_tb: done, errors");
      end
      $finish;
   end

endmodule
